@@ rtl/core/lscp_pkg.sv @@
// Package for the line sensor centroid and PID block.
// Holds field widths, register indexes, reset values and the sequencer state type.
// No dependencies.
`default_nettype none

package lscp_pkg;

  // Number of photo sensors on the bar.
  localparam int SENSOR_COUNT_DEF = 15;

  // Field and register widths.
  localparam int WSTEP_W  = 4;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 23;
  localparam int POS_W    = 16;
  localparam int SEEN_W   = 4;
  localparam int DRIVE_W  = 32;
  localparam int INTEG_W  = 24;
  localparam int FRAC_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [WSTEP_W-1:0] WSTEP_RST = 4'd2;
  localparam logic [GAIN_W-1:0]  KP_RST    = 16'd7680;
  localparam logic [GAIN_W-1:0]  KI_RST    = 16'd0;
  localparam logic [GAIN_W-1:0]  KD_RST    = 16'd2560;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 23'd384000;

  // Saturation bounds.
  localparam logic signed [POS_W-1:0]   POS_MAX   = 16'sh7fff;
  localparam logic signed [POS_W-1:0]   POS_MIN   = 16'sh8000;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 32'sh7fff_ffff;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 32'sh8000_0000;
  localparam logic signed [INTEG_W:0]   INTEG_MAX = 25'sh07f_ffff;
  localparam logic signed [INTEG_W:0]   INTEG_MIN = 25'sh180_0000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCALE,
    ST_PREP,
    ST_DIVIDE,
    ST_POSN,
    ST_INTEG,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACCUM,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/line_sensor_centroid_pid.sv @@
// Top level of the line sensor centroid and PID block.
// Depends on lscp_pkg for widths, register indexes, reset values and state type.
`default_nettype none

// The block takes one sensor mask per transaction and returns one result transaction
// with the line position (signed Q.8 mean weight of the active sensors), the number of
// active sensors, a line-lost flag and the saturated PID drive. The next mask is taken
// only once the result of the last one has been loaded into the output register.
// A sequencer walks the mask one sensor per cycle, a restoring divider produces one
// quotient bit per cycle (20 bits at 15 sensors, skipped when the line is lost), and a
// single shared 25x17 multiplier serves the weight scaling and the three PID terms in
// turn. While a mask is in work in_stall_o is high; a finished result waits in the
// output register so the next mask may be taken meanwhile. Configuration is written
// through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write it only while the
// block is idle, which the block itself does not enforce.
module line_sensor_centroid_pid
  import lscp_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration write port.
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data_i,
  // Input channel.
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [SENSOR_COUNT-1:0]   sensor_mask_i,
  // Output channel.
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [POS_W-1:0]        position_o,
  output logic [SEEN_W-1:0]              sensors_seen_o,
  output logic                           line_lost_o,
  output logic signed [DRIVE_W-1:0]      drive_o
);

  // Derived widths.
  localparam int CENTER  = (SENSOR_COUNT - 1) / 2;
  localparam int IDX_W   = $clog2(SENSOR_COUNT);
  localparam int CNT_W   = $clog2(SENSOR_COUNT + 1);
  localparam int ISUM_W  = $clog2(SENSOR_COUNT * SENSOR_COUNT) + 1;
  localparam int MAG_W   = ISUM_W - 1 + WSTEP_W;
  localparam int DVD_W   = MAG_W + FRAC_W;
  localparam int STEP_W  = $clog2(DVD_W);
  localparam int MUL_A_W = INTEG_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DER_W   = POS_W + 1;

  state_e state_q, state_d;

  // Configuration registers.
  logic [WSTEP_W-1:0] wstep_q;
  logic [GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic [LIMIT_W-1:0] limit_q;

  // Persistent loop state.
  logic signed [POS_W-1:0]   last_pos_q;
  logic signed [POS_W-1:0]   prev_err_q;
  logic signed [INTEG_W-1:0] integ_q;

  // Per-transaction working registers.
  logic [SENSOR_COUNT-1:0]   mask_q;
  logic [IDX_W-1:0]          idx_q;
  logic signed [ISUM_W-1:0]  isum_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      neg_q;
  logic [DVD_W-1:0]          quo_q;
  logic [CNT_W-1:0]          rem_q;
  logic [STEP_W-1:0]         step_q;
  logic signed [POS_W-1:0]   pos_q;
  logic signed [DER_W-1:0]   deriv_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  acc_q;

  // Output registers.
  logic                      out_valid_q;
  logic signed [POS_W-1:0]   out_pos_q;
  logic [SEEN_W-1:0]         out_seen_q;
  logic                      out_lost_q;
  logic signed [DRIVE_W-1:0] out_drive_q;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic in_take, out_free, lost;
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign lost     = (cnt_q == '0);

  // Magnitude of the index sum.
  logic [ISUM_W-1:0] isum_mag;
  assign isum_mag = isum_q[ISUM_W-1] ? (~isum_q + 1'b1) : isum_q;

  // One restoring division step: shift in the next dividend bit and try the count.
  logic [CNT_W:0]   div_trial;
  logic             div_ge;
  logic [CNT_W-1:0] div_rem;
  assign div_trial = {rem_q, quo_q[DVD_W-1]};
  assign div_ge    = (div_trial >= {1'b0, cnt_q});
  assign div_rem   = div_ge ? CNT_W'(div_trial - {1'b0, cnt_q}) : div_trial[CNT_W-1:0];

  // Signed, saturated position from the quotient, or the last position when the line is lost.
  logic signed [POS_W-1:0] pos_new;
  always_comb begin
    if (lost) begin
      pos_new = last_pos_q;
    end else if (!neg_q) begin
      pos_new = (quo_q > DVD_W'(POS_MAX)) ? POS_MAX : quo_q[POS_W-1:0];
    end else begin
      pos_new = (quo_q > DVD_W'(POS_MAX) + 1'b1) ? POS_MIN : POS_W'(DVD_W'(0) - quo_q);
    end
  end

  // Integral update with the optional limit and the 24-bit range.
  logic signed [MUL_A_W-1:0] integ_sum, integ_lim, integ_new;
  logic signed [INTEG_W-1:0] integ_sat;
  always_comb begin
    integ_sum = MUL_A_W'(integ_q) + MUL_A_W'(pos_q);
    integ_lim = signed'(MUL_A_W'(limit_q));
    integ_new = integ_sum;
    if (limit_q != '0) begin
      if (integ_sum > integ_lim) begin
        integ_new = integ_lim;
      end else if (integ_sum < -integ_lim) begin
        integ_new = -integ_lim;
      end
    end
    if (integ_new > INTEG_MAX) begin
      integ_sat = INTEG_MAX[INTEG_W-1:0];
    end else if (integ_new < INTEG_MIN) begin
      integ_sat = INTEG_MIN[INTEG_W-1:0];
    end else begin
      integ_sat = integ_new[INTEG_W-1:0];
    end
  end

  // Drive: floor shift of the accumulated terms, then saturation to 32 bits.
  logic signed [PROD_W-1:0]  acc_sh;
  logic signed [DRIVE_W-1:0] drive_new;
  logic                      drive_ovf;
  assign acc_sh    = acc_q >>> FRAC_W;
  assign drive_ovf = (acc_sh[PROD_W-1:DRIVE_W-1] != '0) && (acc_sh[PROD_W-1:DRIVE_W-1] != '1);
  assign drive_new = drive_ovf ? (acc_sh[PROD_W-1] ? DRIVE_MIN : DRIVE_MAX)
                               : acc_sh[DRIVE_W-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_take) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == IDX_W'(SENSOR_COUNT - 1)) state_d = ST_SCALE;
      ST_SCALE:  state_d = lost ? ST_POSN : ST_PREP;
      ST_PREP:   state_d = ST_DIVIDE;
      ST_DIVIDE: if (step_q == STEP_W'(DVD_W - 1)) state_d = ST_POSN;
      ST_POSN:   state_d = ST_INTEG;
      ST_INTEG:  state_d = ST_MUL_P;
      ST_MUL_P:  state_d = ST_MUL_I;
      ST_MUL_I:  state_d = ST_MUL_D;
      ST_MUL_D:  state_d = ST_ACCUM;
      ST_ACCUM:  state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and operand selection for the shared multiplier.
  always_comb begin
    in_stall_o = 1'b1;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_SCALE: begin
        mul_a = signed'(MUL_A_W'(isum_mag));
        mul_b = signed'(MUL_B_W'(wstep_q));
      end
      ST_MUL_P: begin
        mul_a = MUL_A_W'(pos_q);
        mul_b = signed'({1'b0, kp_q});
      end
      ST_MUL_I: begin
        mul_a = MUL_A_W'(integ_q);
        mul_b = signed'({1'b0, ki_q});
      end
      ST_MUL_D: begin
        mul_a = MUL_A_W'(deriv_q);
        mul_b = signed'({1'b0, kd_q});
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // State register, configuration and loop state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wstep_q    <= WSTEP_RST;
      kp_q       <= KP_RST;
      ki_q       <= KI_RST;
      kd_q       <= KD_RST;
      limit_q    <= LIMIT_RST;
      last_pos_q <= '0;
      prev_err_q <= '0;
      integ_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WEIGHT_STEP: wstep_q <= cfg_data_i[WSTEP_W-1:0];
          REG_PROP_GAIN:   kp_q    <= cfg_data_i[GAIN_W-1:0];
          REG_INTEG_GAIN:  ki_q    <= cfg_data_i[GAIN_W-1:0];
          REG_DERIV_GAIN:  kd_q    <= cfg_data_i[GAIN_W-1:0];
          REG_INTEG_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (state_q == ST_POSN && !lost) begin
        last_pos_q <= pos_new;
      end
      if (state_q == ST_INTEG) begin
        integ_q    <= integ_sat;
        prev_err_q <= pos_q;
      end
      // The output register frees when taken and loads when a result finishes.
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        mask_q <= sensor_mask_i;
        idx_q  <= '0;
        isum_q <= '0;
        cnt_q  <= '0;
      end
      ST_SCAN: begin
        if (mask_q[idx_q]) begin
          isum_q <= isum_q + signed'(ISUM_W'(idx_q)) - signed'(ISUM_W'(CENTER));
          cnt_q  <= cnt_q + 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
      ST_SCALE: begin
        prod_q <= mul_p;
        neg_q  <= isum_q[ISUM_W-1];
      end
      ST_PREP: begin
        quo_q  <= {prod_q[MAG_W-1:0], FRAC_W'(0)};
        rem_q  <= '0;
        step_q <= '0;
      end
      ST_DIVIDE: begin
        quo_q  <= {quo_q[DVD_W-2:0], div_ge};
        rem_q  <= div_rem;
        step_q <= step_q + 1'b1;
      end
      ST_POSN: begin
        pos_q <= pos_new;
      end
      ST_INTEG: begin
        deriv_q <= DER_W'(pos_q) - DER_W'(prev_err_q);
      end
      ST_MUL_P: begin
        prod_q <= mul_p;
      end
      ST_MUL_I: begin
        prod_q <= mul_p;
        acc_q  <= prod_q;
      end
      ST_MUL_D: begin
        prod_q <= mul_p;
        acc_q  <= acc_q + prod_q;
      end
      ST_ACCUM: begin
        acc_q <= acc_q + prod_q;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_pos_q   <= pos_q;
          out_seen_q  <= (cnt_q > CNT_W'(15)) ? SEEN_W'(15) : SEEN_W'(cnt_q);
          out_lost_q  <= lost;
          out_drive_q <= drive_new;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = out_pos_q;
  assign sensors_seen_o = out_seen_q;
  assign line_lost_o    = out_lost_q;
  assign drive_o        = out_drive_q;

endmodule

`default_nettype wire
